// ----- design/itoa_pkg.sv -----
// Shared types, constants and the digit character function for the radix converter.
package itoa_pkg;

  // Width of the value field on the input port
  localparam int FIELD_W = 32;
  // Default conversion width
  localparam int VALUE_WIDTH_DEF = 32;
  // Reciprocal of ten: q = (n * RECIP_DEC) >> RECIP_SHIFT for any 32-bit n
  localparam logic [FIELD_W-1:0] RECIP_DEC = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;
  // ASCII minus sign
  localparam logic [7:0] MINUS_CHAR = 8'd45;
  localparam logic [7:0] ZERO_CHAR = 8'd48;
  localparam logic [7:0] LOWER_A_CHAR = 8'd97;
  // Digit widths
  localparam int DIGIT_W = 4;
  localparam int BASE_W = 5;
  localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
  localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
  localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

  // Conversion selector codes
  typedef enum logic [1:0] {
    ACT_SDEC = 2'd0,
    ACT_UDEC = 2'd1,
    ACT_SOCT = 2'd2,
    ACT_SHEX = 2'd3
  } action_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV_A = 2'd1,
    ST_DIV_B = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  // Control from the sequencer to the divide unit
  typedef struct packed {
    logic    load;
    action_e act;
  } div_ctrl_t;

  // Digit value to lowercase ASCII
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ZERO_CHAR + {4'b0, d};
    end else begin
      c = LOWER_A_CHAR + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- design/itoa_div.sv -----
// Shared divide-by-base unit: registered quotient, then remainder by shift-add and subtract.
module itoa_div #(
  parameter int MAG_W = itoa_pkg::FIELD_W
) (
  input  logic                       clk_i,
  input  itoa_pkg::div_ctrl_t        ctrl_i,
  input  logic [MAG_W-1:0]           mag_i,
  output logic [MAG_W-1:0]           quot_o,
  output logic [itoa_pkg::DIGIT_W-1:0] rem_o
);
  import itoa_pkg::*;

  localparam int ProdW = 2 * FIELD_W;

  logic [FIELD_W-1:0] op;
  logic [ProdW-1:0]   prod;
  logic [MAG_W-1:0]   quot_d, quot_q;
  logic [MAG_W-1:0]   qb;

  // Quotient: reciprocal multiply for ten, plain shift for eight and sixteen
  assign op   = FIELD_W'(mag_i);
  assign prod = ProdW'(op) * ProdW'(RECIP_DEC);

  always_comb begin
    case (ctrl_i.act)
      ACT_SOCT: quot_d = mag_i >> 3;
      ACT_SHEX: quot_d = mag_i >> 4;
      default:  quot_d = MAG_W'(prod >> RECIP_SHIFT);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      quot_q <= quot_d;
    end
  end

  // Remainder: mag - quot * base, only the low digit bits matter
  always_comb begin
    case (ctrl_i.act)
      ACT_SOCT: qb = quot_q << 3;
      ACT_SHEX: qb = quot_q << 4;
      default:  qb = (quot_q << 3) + (quot_q << 1);
    endcase
  end

  assign quot_o = quot_q;
  assign rem_o  = DIGIT_W'(mag_i - qb);

endmodule

// ----- design/itoa_dbuf.sv -----
// Digit buffer: collects digits least significant first, read back by index, registered.
module itoa_dbuf #(
  parameter int DEPTH = 11,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          push_i,
  input  logic [itoa_pkg::DIGIT_W-1:0]  digit_i,
  input  logic [IDX_W-1:0]              rd_idx_i,
  output logic [itoa_pkg::DIGIT_W-1:0]  rd_digit_o,
  output logic [CNT_W-1:0]              cnt_o
);
  import itoa_pkg::*;

  logic [DIGIT_W-1:0] dig_q [DEPTH];
  logic [DIGIT_W-1:0] rd_digit_q;
  logic [IDX_W-1:0]   wr_idx;
  logic [CNT_W-1:0]   cnt_d, cnt_q;

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (clear_i) begin
      cnt_d = '0;
    end else if (push_i) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign wr_idx = cnt_q[IDX_W-1:0];

  // Digit storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      dig_q[wr_idx] <= digit_i;
    end
  end

  // Registered read; a digit written at the read address passes straight through
  always_ff @(posedge clk_i) begin
    if (push_i && (wr_idx == rd_idx_i)) begin
      rd_digit_q <= digit_i;
    end else begin
      rd_digit_q <= dig_q[rd_idx_i];
    end
  end

  assign rd_digit_o = rd_digit_q;
  assign cnt_o      = cnt_q;

endmodule

// ----- design/integer_to_ascii_radix_converter_unit.sv -----
// Top level: sequencer, sign handling and output word register of the radix converter.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | sink      | in_valid_i / in_stall_o   | action_i, value_i
//  out     | source    | out_valid_o / out_stall_i | character_o, last_o
//
// One input word at a time. Each digit passes through the shared divide unit
// in state ST_DIV_A (registered quotient), then ST_DIV_B (remainder); then the
// item's n digit words (plus one for a minus sign) leave at one per cycle when
// the output is not stalled. The longest item is an 11-digit negative octal
// word. Reset clears the sequencer and output valid.
// Output stalls only stretch the emit phase.
module integer_to_ascii_radix_converter_unit #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  character_o,
  output logic        last_o
);
  import itoa_pkg::*;

  localparam int MagW    = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam bit HasSign = (VALUE_WIDTH <= FIELD_W);
  localparam int DigN    = (MagW + 2) / 3;
  localparam int CntW    = $clog2(DigN + 1);
  localparam int IdxW    = $clog2(DigN);

  state_e             state_d, state_q;
  action_e            act_d, act_q;
  logic               neg_d, neg_q;
  logic [MagW-1:0]    mag_d, mag_q;
  logic [IdxW-1:0]    idx_d, idx_q;
  logic               out_valid_d, out_valid_q;
  logic [7:0]         char_d, char_q;
  logic               last_d, last_q;

  logic [MagW-1:0]    val_in;
  logic               sign_in;
  div_ctrl_t          div_ctrl;
  logic [MagW-1:0]    quot;
  logic [DIGIT_W-1:0] rem;
  logic               buf_clear, buf_push;
  logic [DIGIT_W-1:0] rd_digit;
  logic [CntW-1:0]    dig_cnt;
  logic               out_load;
  logic [BASE_W-1:0]  base_lim;

  // Input sign and magnitude
  assign val_in  = value_i[MagW-1:0];
  assign sign_in = HasSign && (action_e'(action_i) != ACT_UDEC) && val_in[MagW-1];

  itoa_div #(
    .MAG_W (MagW)
  ) u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .mag_i  (mag_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // Buffer reads the next index so its registered digit lines up with idx_q
  itoa_dbuf #(
    .DEPTH (DigN),
    .CNT_W (CntW),
    .IDX_W (IdxW)
  ) u_dbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (buf_clear),
    .push_i     (buf_push),
    .digit_i    (rem),
    .rd_idx_i   (idx_d),
    .rd_digit_o (rd_digit),
    .cnt_o      (dig_cnt)
  );

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d       = state_q;
    act_d         = act_q;
    neg_d         = neg_q;
    mag_d         = mag_q;
    idx_d         = idx_q;
    div_ctrl.load = 1'b0;
    div_ctrl.act  = act_q;
    buf_clear     = 1'b0;
    buf_push      = 1'b0;
    out_load      = 1'b0;
    char_d        = char_q;
    last_d        = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_e'(action_i);
          neg_d     = sign_in;
          mag_d     = sign_in ? (MagW'(0) - val_in) : val_in;
          buf_clear = 1'b1;
          state_d   = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        div_ctrl.load = 1'b1;
        state_d       = ST_DIV_B;
      end
      ST_DIV_B: begin
        buf_push = 1'b1;
        mag_d    = quot;
        if (quot == '0) begin
          idx_d   = IdxW'(dig_cnt);
          state_d = ST_EMIT;
        end else begin
          state_d = ST_DIV_A;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (neg_q) begin
            char_d = MINUS_CHAR;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = digit_char(rd_digit);
            last_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output word register
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    mag_q  <= mag_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Base of the current conversion, for checking
  always_comb begin
    case (act_q)
      ACT_SOCT: base_lim = BASE_OCT;
      ACT_SHEX: base_lim = BASE_HEX;
      default:  base_lim = BASE_DEC;
    endcase
  end

  // Accepted word starts a division with an empty digit buffer
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_DIV_A && dig_cnt == '0)
    else $error("conversion did not start cleanly");

  // Remainder is always a digit of the selected base
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_B |-> {1'b0, rem} < base_lim)
    else $error("remainder out of range");

  // Emitting always has at least one digit buffered
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> dig_cnt != '0 && CntW'(idx_q) < dig_cnt)
    else $error("emit index outside digit buffer");

  // Minus sign never ends a conversion
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> character_o != MINUS_CHAR)
    else $error("last word is a minus sign");

endmodule
